FILE: sv/assert_macros.svh
// assertion macros used by lfu_cache_table, the one rtl file that checks itself
// depends on nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define LFU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// same, on the block clock and reset names
`define LFU_ASSERT_TOP(label, prop, msg) \
  `LFU_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

FILE: sv/lfu_pkg.sv
// types and constants of the lfu cache table
// depends on nothing
`default_nettype none
package lfu_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned CAP_W          = 5;
  localparam int unsigned KEY_W          = 32;
  localparam int unsigned DATA_W         = 32;
  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_PUT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_e;

endpackage
`default_nettype wire

FILE: sv/lfu_if.sv
// valid/ready channels of the lfu cache table: request, response, config
// depends on lfu_pkg
`default_nettype none
interface lfu_req_if;
  import lfu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [KEY_W-1:0]  lookup_key;
  logic signed [DATA_W-1:0] store_value;
  modport source (output valid, kind, lookup_key, store_value, input ready);
  modport sink   (input valid, kind, lookup_key, store_value, output ready);
endinterface

interface lfu_rsp_if;
  import lfu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [DATA_W-1:0] read_value;
  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

interface lfu_cfg_if;
  import lfu_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;
  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface
`default_nettype wire

FILE: sv/lfu_cache_table.sv
// lfu cache table: an item is accepted, walked DEPTH scan steps down the cell chain, then
// applied in an update state; one item in flight, next accepted once the update is done
// throughput is set by the scan record walking one cell per cycle
// a get result sits in an output register; the block takes the next item while it waits
// reset clears all entry valid bits at once and sets capacity to 16; no clearing pass
`default_nettype none
`include "assert_macros.svh"
module lfu_cache_table #(
  parameter int unsigned DEPTH      = lfu_pkg::DEPTH_DEF,
  parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lfu_req_if.sink   req_i,
  lfu_rsp_if.source rsp_o,
  lfu_cfg_if.sink   cfg_i
);
  import lfu_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned UW    = $clog2(DEPTH + 1);

  typedef struct packed {
    logic                  hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      hit_rank;
    logic [DATA_W-1:0]     hit_data;
    logic                  free;
    logic [IDX_W-1:0]      free_idx;
    logic [UW-1:0]         used;
    logic                  vic;
    logic [IDX_W-1:0]      vic_idx;
    logic [COUNT_BITS-1:0] vic_cnt;
    logic [IDX_W-1:0]      vic_rank;
  } rec_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  tgt;
    logic [IDX_W-1:0]  thr;
    logic              age_all;
    logic              insert;
    logic              wr_data;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } cmd_t;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic [CAP_W-1:0]  cap_q;
  logic              kind_q;
  logic [KEY_W-1:0]  key_q;
  logic [DATA_W-1:0] val_q;
  logic              out_valid_q, out_valid_d;
  logic              out_hit_q, out_hit_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic              req_xfer, out_free;
  logic [31:0]       cap_lim;
  logic              full;
  rec_t              rec_w [DEPTH];
  rec_t              rec_fin;
  cmd_t              cmd;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == S_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.hit        = out_hit_q;
  assign rsp_o.read_value = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      cap_q <= cfg_i.capacity;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      kind_q <= req_i.kind;
      key_q  <= req_i.lookup_key;
      val_q  <= req_i.store_value;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      rec_t rec_in;
      if (gi == 0) begin : g_head
        assign rec_in = '0;
      end else begin : g_link
        assign rec_in = rec_w[gi-1];
      end
      lfu_cell #(
        .IDX        (gi),
        .IDX_W      (IDX_W),
        .COUNT_BITS (COUNT_BITS),
        .rec_t      (rec_t),
        .cmd_t      (cmd_t)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .key_i  (key_q),
        .rec_i  (rec_in),
        .rec_o  (rec_w[gi]),
        .cmd_i  (cmd)
      );
    end
  endgenerate

  assign rec_fin = rec_w[DEPTH-1];
  assign cap_lim = (32'(cap_q) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(cap_q);
  assign full    = 32'(rec_fin.used) >= cap_lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hit_q  <= out_hit_d;
    out_data_q <= out_data_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_hit_d   = out_hit_q;
    out_data_d  = out_data_q;
    cmd         = '0;
    cmd.key     = key_q;
    cmd.data    = val_q;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (req_xfer) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q == IDX_W'(DEPTH - 1)) begin
          state_d = S_APPLY;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      S_APPLY: begin
        if (kind_q == KIND_GET) begin
          if (out_free) begin
            state_d     = S_IDLE;
            out_valid_d = 1'b1;
            if (cap_q != '0 && rec_fin.hit) begin
              out_hit_d = 1'b1;
              out_data_d = rec_fin.hit_data;
              cmd.en  = 1'b1;
              cmd.tgt = rec_fin.hit_idx;
              cmd.thr = rec_fin.hit_rank;
            end else begin
              out_hit_d  = 1'b0;
              out_data_d = MISS_VALUE;
            end
          end
        end else begin
          state_d = S_IDLE;
          if (cap_q != '0) begin
            cmd.en = 1'b1;
            if (rec_fin.hit) begin
              cmd.tgt     = rec_fin.hit_idx;
              cmd.thr     = rec_fin.hit_rank;
              cmd.wr_data = 1'b1;
            end else if (full) begin
              cmd.tgt    = rec_fin.vic_idx;
              cmd.thr    = rec_fin.vic_rank;
              cmd.insert = 1'b1;
            end else begin
              cmd.tgt     = rec_fin.free_idx;
              cmd.age_all = 1'b1;
              cmd.insert  = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `LFU_ASSERT_TOP(a_cmd_ends_item, cmd.en |=> state_q == S_IDLE, "update not at end of item")
  `LFU_ASSERT_TOP(a_rsp_from_apply, $rose(out_valid_q) |-> $past(state_q) == S_APPLY, "stray result")
  `LFU_ASSERT_TOP(a_scan_len, state_q == S_APPLY |-> cnt_q == IDX_W'(DEPTH - 1), "short scan")
  `LFU_ASSERT_TOP(a_put_no_rsp, (state_q == S_APPLY && kind_q == KIND_PUT) |=> !$rose(out_valid_q), "put gave result")

endmodule
`default_nettype wire

FILE: sv/lfu_cell.sv
// one table entry: key, data, use count and recency rank, with its stage of the scan chain
// depends on lfu_pkg; record and command types come from the top level
`default_nettype none
module lfu_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned COUNT_BITS = 16,
  parameter type         rec_t      = logic,
  parameter type         cmd_t      = logic
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [lfu_pkg::KEY_W-1:0]   key_i,
  input  wire rec_t                        rec_i,
  output rec_t                             rec_o,
  input  wire cmd_t                        cmd_i
);
  import lfu_pkg::*;

  logic                  valid_q;
  logic [KEY_W-1:0]      key_q;
  logic [DATA_W-1:0]     data_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [IDX_W-1:0]      rank_q;
  rec_t                  rec_d, rec_q;
  logic                  match, take_vic, is_tgt;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  always_comb begin
    match    = valid_q && (key_q == key_i);
    take_vic = valid_q && (!rec_i.vic || cnt_q < rec_i.vic_cnt ||
               (cnt_q == rec_i.vic_cnt && rank_q > rec_i.vic_rank));
    rec_d      = rec_i;
    rec_d.used = rec_i.used + $bits(rec_i.used)'(valid_q);
    if (!rec_i.hit && match) begin
      rec_d.hit      = 1'b1;
      rec_d.hit_idx  = MY_IDX;
      rec_d.hit_rank = rank_q;
      rec_d.hit_data = data_q;
    end
    if (!rec_i.free && !valid_q) begin
      rec_d.free     = 1'b1;
      rec_d.free_idx = MY_IDX;
    end
    if (take_vic) begin
      rec_d.vic      = 1'b1;
      rec_d.vic_idx  = MY_IDX;
      rec_d.vic_cnt  = cnt_q;
      rec_d.vic_rank = rank_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o  = rec_q;
  assign is_tgt = (cmd_i.tgt == MY_IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.en && is_tgt) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.en) begin
      if (is_tgt) begin
        rank_q <= '0;
        if (cmd_i.insert) begin
          key_q  <= cmd_i.key;
          data_q <= cmd_i.data;
          cnt_q  <= COUNT_BITS'(1);
        end else begin
          if (cnt_q != '1) begin
            cnt_q <= cnt_q + COUNT_BITS'(1);
          end
          if (cmd_i.wr_data) begin
            data_q <= cmd_i.data;
          end
        end
      end else if (valid_q && (cmd_i.age_all || rank_q < cmd_i.thr)) begin
        rank_q <= rank_q + IDX_W'(1);
      end
    end
  end

endmodule
`default_nettype wire
